[hdl/multicycle_cpu_with_dma_top_defines.svh]
// Assertion macros used by the multicycle processor top level.
`ifndef MULTICYCLE_CPU_WITH_DMA_TOP_DEFINES_SVH
`define MULTICYCLE_CPU_WITH_DMA_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define MCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define MCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define MCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[hdl/mcd_pkg.sv]
// Package with the shared types and constants of the multicycle processor.
`default_nettype none
package mcd_pkg;
	localparam int MemWordsDefault = 65536;
	localparam logic [1:0] ReqTick  = 2'd0;
	localparam logic [1:0] ReqLoad  = 2'd1;
	localparam logic [1:0] ReqRead  = 2'd2;
	localparam logic [1:0] ReqStart = 2'd3;

	localparam logic [4:0] OpAdd = 5'd0;
	localparam logic [4:0] OpSub = 5'd1;
	localparam logic [4:0] OpLsf = 5'd2;
	localparam logic [4:0] OpRsf = 5'd3;
	localparam logic [4:0] OpAnd = 5'd4;
	localparam logic [4:0] OpOr  = 5'd5;
	localparam logic [4:0] OpXor = 5'd6;
	localparam logic [4:0] OpLhi = 5'd7;
	localparam logic [4:0] OpLd  = 5'd8;
	localparam logic [4:0] OpSt  = 5'd9;
	localparam logic [4:0] OpDma = 5'd10;
	localparam logic [4:0] OpPol = 5'd11;
	localparam logic [4:0] OpJlt = 5'd16;
	localparam logic [4:0] OpJle = 5'd17;
	localparam logic [4:0] OpJeq = 5'd18;
	localparam logic [4:0] OpJne = 5'd19;
	localparam logic [4:0] OpJin = 5'd20;
	localparam logic [4:0] OpHlt = 5'd24;

	localparam int OpcLsb = 25;
	localparam int DstLsb = 22;
	localparam int Src0Lsb = 19;
	localparam int Src1Lsb = 16;

	typedef struct packed {
		logic [1:0] req;
	} mcd_in_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic tick;
		logic load;
		logic read;
		logic start;
		logic idle_clr;
		logic fetch0;
		logic fetch1;
		logic dec0;
		logic dec1;
		logic exec0;
		logic exec1;
		logic halt_ret;
	} mcd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [4:0] opcode;
	} mcd_sts_t;

	typedef struct packed {
		logic [31:0] read_word;
		logic running;
		logic halted_now;
		logic [15:0] current_address;
		logic copy_busy;
	} mcd_out_t;
endpackage
`default_nettype wire

[hdl/mcd_if.sv]
// Valid/ready channel interfaces for requests and results.
`default_nettype none
interface mcd_req_if;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [15:0] word_address;
	logic [31:0] write_word;
	modport source (output valid, req_type, word_address, write_word, input ready);
	modport sink (input valid, req_type, word_address, write_word, output ready);
endinterface

interface mcd_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] read_word;
	logic running;
	logic halted_now;
	logic [15:0] current_address;
	logic copy_busy;
	modport source (output valid, read_word, running, halted_now, current_address,
		copy_busy, input ready);
	modport sink (input valid, read_word, running, halted_now, current_address,
		copy_busy, output ready);
endinterface
`default_nettype wire

[hdl/mcd_ctrl.sv]
// Instruction phase sequencer of the multicycle processor.
`default_nettype none
module mcd_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic [1:0] req,
	input  wire mcd_pkg::mcd_sts_t sts,
	output mcd_pkg::mcd_cmd_t cmd,
	output logic running
);
	import mcd_pkg::*;

	typedef enum logic [2:0] {
		PhIdle, PhFetch0, PhFetch1, PhDec0, PhDec1, PhExec0, PhExec1
	} phase_t;

	phase_t phase_q;
	logic tick;

	assign tick = go && (req == ReqTick);
	assign running = (phase_q != PhIdle);

	always_comb begin
		cmd = '0;
		cmd.tick = tick;
		cmd.load = go && (req == ReqLoad) && (phase_q == PhIdle);
		cmd.read = go && (req == ReqRead) && (phase_q == PhIdle);
		cmd.start = go && (req == ReqStart) && (phase_q == PhIdle);
		cmd.idle_clr = tick && (phase_q == PhIdle);
		cmd.fetch0 = tick && (phase_q == PhFetch0);
		cmd.fetch1 = tick && (phase_q == PhFetch1);
		cmd.dec0 = tick && (phase_q == PhDec0);
		cmd.dec1 = tick && (phase_q == PhDec1);
		cmd.exec0 = tick && (phase_q == PhExec0);
		cmd.exec1 = tick && (phase_q == PhExec1);
		cmd.halt_ret = cmd.exec1 && (sts.opcode == OpHlt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PhIdle;
		end else if (cmd.start) begin
			phase_q <= PhFetch0;
		end else if (tick) begin
			case (phase_q)
				PhIdle:   phase_q <= PhIdle;
				PhFetch0: phase_q <= PhFetch1;
				PhFetch1: phase_q <= PhDec0;
				PhDec0:   phase_q <= PhDec1;
				PhDec1:   phase_q <= PhExec0;
				PhExec0:  phase_q <= PhExec1;
				PhExec1:  phase_q <= (sts.opcode == OpHlt) ? PhIdle : PhFetch0;
				default:  phase_q <= PhIdle;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/mcd_dp.sv]
// Register file, ALU, SRAM and block-copy engine of the processor.
`default_nettype none
module mcd_dp #(
	parameter int MEM_WORDS = mcd_pkg::MemWordsDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire mcd_pkg::mcd_cmd_t cmd,
	input  wire logic [15:0] word_address,
	input  wire logic [31:0] write_word,
	output mcd_pkg::mcd_sts_t sts,
	output logic [31:0] read_word,
	output logic [15:0] pc,
	output logic copy_busy
);
	import mcd_pkg::*;

	localparam int AW = $clog2(MEM_WORDS);

	typedef enum logic [1:0] {CpIdle, CpRead, CpSample, CpWrite} cp_t;

	logic [31:0] mem [MEM_WORDS];
	logic [31:0] rdata_q;
	logic [31:0] port_save_q;
	logic port_hold_q;
	logic rd_ret_q;
	logic [31:0] regs_q [2:7];
	logic [15:0] pc_q;
	logic [31:0] ir_q;
	logic [4:0]  op_q;
	logic [2:0]  dst_q, s0_q, s1_q;
	logic [31:0] imm_q, a_q, b_q, alu_q;
	logic [15:0] cra_q, cwa_q, crem_q;
	logic [31:0] cword_q;
	cp_t cp_q;

	logic ip_busy, ip_busy_nx, cp_go;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;
	logic [31:0] port_data;
	logic [31:0] alu_val;
	logic [31:0] ra, rb, rd_dst;
	logic lt, eq;
	logic [4:0] next_op;

	function automatic logic [31:0] rf(input logic [2:0] r, input logic [31:0] imm,
		input logic [31:0] g2, input logic [31:0] g3, input logic [31:0] g4,
		input logic [31:0] g5, input logic [31:0] g6, input logic [31:0] g7);
		logic [31:0] v;
		case (r)
			3'd0: v = '0;
			3'd1: v = imm;
			3'd2: v = g2;
			3'd3: v = g3;
			3'd4: v = g4;
			3'd5: v = g5;
			3'd6: v = g6;
			default: v = g7;
		endcase
		return v;
	endfunction

	assign sts.opcode = op_q;
	assign pc = pc_q;
	assign copy_busy = (cp_q != CpIdle);

	assign ra = rf(s0_q, imm_q, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
		regs_q[6], regs_q[7]);
	assign rb = rf(s1_q, imm_q, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
		regs_q[6], regs_q[7]);
	assign rd_dst = rf(dst_q, imm_q, regs_q[2], regs_q[3], regs_q[4], regs_q[5],
		regs_q[6], regs_q[7]);

	// Port use by the instruction path in this and the next phase.
	assign ip_busy = cmd.fetch0 || (cmd.exec0 && op_q == OpLd) ||
		(cmd.exec1 && op_q == OpSt);
	assign next_op = cmd.dec0 ? ir_q[OpcLsb +: 5] : op_q;
	assign ip_busy_nx = (cmd.exec1 && op_q != OpHlt) || cmd.idle_clr && 1'b0 ||
		(cmd.dec1 && next_op == OpLd) || (cmd.exec0 && next_op == OpSt);
	assign cp_go = cmd.tick && !ip_busy;

	assign lt = $signed(a_q) < $signed(b_q);
	assign eq = (a_q == b_q);

	always_comb begin
		case (op_q)
			OpAdd: alu_val = a_q + b_q;
			OpSub: alu_val = a_q - b_q;
			OpLsf: alu_val = (b_q >= 32'd32) ? '0 : (a_q << b_q[4:0]);
			OpRsf: alu_val = (b_q >= 32'd32) ? {32{a_q[31]}}
				: 32'($signed(a_q) >>> b_q[4:0]);
			OpAnd: alu_val = a_q & b_q;
			OpOr:  alu_val = a_q | b_q;
			OpXor: alu_val = a_q ^ b_q;
			OpLhi: alu_val = {imm_q[15:0], a_q[15:0]};
			OpJlt: alu_val = {31'd0, lt};
			OpJle: alu_val = {31'd0, lt || eq};
			OpJeq: alu_val = {31'd0, eq};
			OpJne: alu_val = {31'd0, !eq};
			OpJin: alu_val = 32'd1;
			default: alu_val = '0;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = word_address[AW-1:0];
		mem_ra = word_address[AW-1:0];
		mem_wd = write_word;
		if (cmd.load) begin
			mem_we = 1'b1;
		end else if (cmd.read) begin
			mem_re = 1'b1;
		end else if (cmd.fetch0) begin
			mem_re = 1'b1;
			mem_ra = pc_q[AW-1:0];
		end else if (cmd.exec0 && op_q == OpLd) begin
			mem_re = 1'b1;
			mem_ra = b_q[AW-1:0];
		end else if (cmd.exec1 && op_q == OpSt) begin
			mem_we = 1'b1;
			mem_wa = b_q[AW-1:0];
			mem_wd = a_q;
		end else if (cp_go && cp_q == CpRead && !ip_busy_nx) begin
			mem_re = 1'b1;
			mem_ra = cra_q[AW-1:0];
		end else if (cp_go && cp_q == CpWrite) begin
			mem_we = 1'b1;
			mem_wa = cwa_q[AW-1:0];
			mem_wd = cword_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdata_q <= '0;
		end else if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// A read request borrows the SRAM output register. The word that the
	// processor side last read is parked until a tick reads the SRAM again.
	assign port_data = port_hold_q ? port_save_q : rdata_q;
	assign read_word = rd_ret_q ? rdata_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_hold_q <= 1'b0;
			port_save_q <= '0;
			rd_ret_q <= 1'b0;
		end else begin
			if (cmd.read) begin
				port_hold_q <= 1'b1;
				port_save_q <= port_data;
			end else if (mem_re) begin
				port_hold_q <= 1'b0;
			end
			if (cmd.tick || cmd.load || cmd.read || cmd.start) rd_ret_q <= cmd.read;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 2; i < 8; i++) regs_q[i] <= '0;
			pc_q <= '0;
			ir_q <= '0;
			op_q <= '0;
			dst_q <= '0;
			s0_q <= '0;
			s1_q <= '0;
			imm_q <= '0;
			a_q <= '0;
			b_q <= '0;
			alu_q <= '0;
			cra_q <= '0;
			cwa_q <= '0;
			crem_q <= '0;
			cword_q <= '0;
			cp_q <= CpIdle;
		end else begin
			if (cmd.start || cmd.idle_clr) pc_q <= '0;
			if (cmd.fetch1) ir_q <= port_data;
			if (cmd.dec0) begin
				pc_q <= pc_q + 16'd1;
				op_q <= ir_q[OpcLsb +: 5];
				dst_q <= ir_q[DstLsb +: 3];
				s0_q <= ir_q[Src0Lsb +: 3];
				s1_q <= ir_q[Src1Lsb +: 3];
				imm_q <= {{16{ir_q[15]}}, ir_q[15:0]};
			end
			if (cmd.dec1) begin
				a_q <= (op_q == OpLhi) ? rd_dst : ra;
				b_q <= rb;
			end
			if (cmd.exec0) begin
				if (op_q <= OpLhi || (op_q >= OpJlt && op_q <= OpJin)) alu_q <= alu_val;
			end
			if (cmd.exec1) begin
				if (op_q <= OpLhi) begin
					if (dst_q >= 3'd2) regs_q[dst_q] <= alu_q;
				end else if (op_q == OpLd) begin
					if (dst_q >= 3'd2) regs_q[dst_q] <= port_data;
				end else if (op_q >= OpJlt && op_q <= OpJin) begin
					if (alu_q != '0) begin
						regs_q[7] <= {16'd0, pc_q - 16'd1};
						pc_q <= imm_q[15:0];
					end
				end else if (op_q == OpPol) begin
					if (dst_q >= 3'd2) regs_q[dst_q] <= {16'd0, crem_q};
				end
			end
			// Copy engine: an instruction-side launch only from idle.
			if (cmd.exec0 && op_q == OpDma && cp_q == CpIdle && imm_q[15:0] != '0) begin
				cra_q <= a_q[15:0];
				cwa_q <= b_q[15:0];
				crem_q <= imm_q[15:0];
				cp_q <= CpRead;
			end else if (cp_go) begin
				case (cp_q)
					CpRead: if (!ip_busy_nx) cp_q <= CpSample;
					CpSample: begin
						cword_q <= port_data;
						cra_q <= cra_q + 16'd1;
						cp_q <= CpWrite;
					end
					CpWrite: begin
						cwa_q <= cwa_q + 16'd1;
						crem_q <= crem_q - 16'd1;
						cp_q <= (crem_q == 16'd1) ? CpIdle : CpRead;
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

[hdl/multicycle_cpu_with_dma_top.sv]
// Top level of the multicycle 32-bit processor with block-copy DMA.
// Usage: every request on the input channel carries req_type: a clock tick
// advances the processor's phases, a load writes write_word into the
// SRAM at word_address, a read returns that word in read_word, and a start
// begins execution at address zero. Loads, reads and starts act only while
// the processor is idle and are otherwise ignored.
// Each request yields exactly one result on the output channel, which also
// reports running, halted_now, current_address and copy_busy.
// The result's valid and halt flags load at the edge that accepts the
// request. Throughput is one request per cycle while the receiver takes
// results; an instruction steps through Fetch0, Fetch1, Dec0, Dec1, Exec0
// and Exec1; copy words are read, sampled, written on free SRAM ticks.
// Reset clears registers, phases and the valid flag but not the halt flag;
// SRAM contents are undefined until written. When the receiver stalls, the
// result is held and ready is dropped until it is taken; no request is lost.
`default_nettype none
`include "multicycle_cpu_with_dma_top_defines.svh"
module multicycle_cpu_with_dma_top #(
	parameter int MEM_WORDS = mcd_pkg::MemWordsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	mcd_req_if.sink  req,
	mcd_rsp_if.source rsp
);
	import mcd_pkg::*;

	mcd_cmd_t cmd;
	mcd_sts_t sts;
	mcd_out_t out_q;
	logic out_valid_q;
	logic go;
	logic running;
	logic copy_busy;
	logic [31:0] read_word;
	logic [15:0] pc;
	logic running_nx;

	// A request is taken whenever the result register is empty or draining.
	assign req.ready = !out_valid_q || rsp.ready;
	assign go = req.valid && req.ready;

	mcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .req(req.req_type),
		.sts(sts), .cmd(cmd), .running(running)
	);

	mcd_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .word_address(req.word_address),
		.write_word(req.write_word), .sts(sts), .read_word(read_word), .pc(pc),
		.copy_busy(copy_busy)
	);

	// Running after this request: start launches, halt retires, else hold.
	assign running_nx = cmd.start || (running && !cmd.halt_ret);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The datapath already registers the read word, so only the halt flag,
	// which is known in the accepting cycle alone, is captured here.
	logic halted_q;
	always_ff @(posedge clk) begin
		if (go) begin
			halted_q <= cmd.halt_ret;
		end
	end

	// After the accepting edge the datapath registers already hold the new
	// state, and they do not move until the next request is accepted.
	always_comb begin
		out_q.read_word = read_word;
		out_q.running = running;
		out_q.halted_now = halted_q;
		out_q.current_address = pc;
		out_q.copy_busy = copy_busy;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.read_word = out_q.read_word;
	assign rsp.running = out_q.running;
	assign rsp.halted_now = out_q.halted_now;
	assign rsp.current_address = out_q.current_address;
	assign rsp.copy_busy = out_q.copy_busy;

	`MCD_ASSERT_NXT(a_start_runs, clk, arst_n, cmd.start, running)
	`MCD_ASSERT_NXT(a_halt_idles, clk, arst_n, cmd.halt_ret, !running)
	`MCD_ASSERT_IMP(a_running_nx, clk, arst_n, go && !cmd.start && !cmd.halt_ret,
		running_nx == running)
endmodule
`default_nettype wire
